// ===== hw/rtl/generational_handle_allocator_defines.svh =====
// ---------------------------------------------------------------------------
// generational handle allocator assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define GHA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gha_pkg.sv =====
// ---------------------------------------------------------------------------
// gha_pkg
// shared types, request modes and constants of the handle allocator
// ---------------------------------------------------------------------------
package gha_pkg;

  localparam int MAX_SLOTS_DEF = 64;

  localparam int MODE_W    = 2;
  localparam int HIDX_W    = 6;
  localparam int VER_W     = 32;
  localparam int LIMIT_W   = 7;
  localparam int LCOUNT_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [MODE_W-1:0] MODE_SPAWN     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DESTROY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [HIDX_W-1:0] handle_index;
    logic [VER_W-1:0]  handle_version;
  } gha_in_t;

  typedef struct packed {
    logic                ok;
    logic [HIDX_W-1:0]   result_index;
    logic [VER_W-1:0]    result_version;
    logic [LCOUNT_W-1:0] live_count;
  } gha_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } gha_state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } gha_cmd_t;

endpackage

// ===== hw/rtl/gha_ram.sv =====
// ---------------------------------------------------------------------------
// gha_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/gha_ctrl.sv =====
// ---------------------------------------------------------------------------
// gha_ctrl
// two-state sequencer: search and version read, then update and result
// ---------------------------------------------------------------------------
`include "generational_handle_allocator_defines.svh"

module gha_ctrl import gha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output logic     cfg_ready,
  output gha_cmd_t cmd
);

  gha_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = !in_valid;
        cmd.load  = in_valid;
      end
      ST_EXEC: begin
        cmd.commit = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `GHA_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid_r, "commit without result")
  `GHA_ASSERT_NEXT(a_load_enters_exec, cmd.load, state_r == ST_EXEC,
                   "load did not start exec")
  `GHA_ASSERT_NEXT(a_exec_waits, (state_r == ST_EXEC) && !cmd.commit,
                   (state_r == ST_EXEC) && out_valid_r, "exec left without commit")

endmodule

// ===== hw/rtl/gha_dpath.sv =====
// ---------------------------------------------------------------------------
// gha_dpath
// reserved bits, lowest-free search, version ram, counters and result register
// ---------------------------------------------------------------------------
`include "generational_handle_allocator_defines.svh"

module gha_dpath import gha_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gha_cmd_t           cmd,
  input  gha_in_t            in_data,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  output gha_out_t           out_data
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  logic [LIMIT_W-1:0]   limit_r;
  logic [CNT_W-1:0]     lim;
  logic [MAX_SLOTS-1:0] reserved_r, reserved_nxt;
  logic [MAX_SLOTS-1:0] vvalid_r, vvalid_nxt;
  logic [CNT_W-1:0]     live_r, live_nxt;
  logic [CNT_W-1:0]     hint_r, hint_nxt;

  gha_in_t              item_r;
  logic                 found_r;
  logic [IDX_W-1:0]     found_idx_r;
  logic                 rd_vvalid_r;
  gha_out_t             out_r, out_nxt;

  logic                 found;
  logic [IDX_W-1:0]     found_idx;
  logic [IDX_W-1:0]     in_hidx;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     hidx;
  logic                 in_range;
  logic [VER_W-1:0]     ram_rd_data;
  logic [VER_W-1:0]     ver_cur;
  logic [VER_W-1:0]     ver_inc;
  logic [VER_W-1:0]     ver_new;
  logic                 ram_we;

  // effective slot limit
  always_comb begin
    if (limit_r == '0) begin
      lim = CNT_W'(1);
    end else if (32'(limit_r) > 32'(MAX_SLOTS)) begin
      lim = CNT_W'(MAX_SLOTS);
    end else begin
      lim = CNT_W'(limit_r);
    end
  end

  // lowest free slot in [hint, lim)
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (!reserved_r[i] && (i >= int'(hint_r)) && (i < int'(lim))) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  assign in_hidx = IDX_W'(in_data.handle_index);
  assign rd_addr = (in_data.mode == MODE_SPAWN) ? found_idx : in_hidx;

  gha_ram #(
    .WIDTH (VER_W),
    .DEPTH (MAX_SLOTS)
  ) u_ver_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (found_idx_r),
    .wr_data (ver_new),
    .rd_en   (cmd.load),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  assign hidx     = IDX_W'(item_r.handle_index);
  assign in_range = 32'(item_r.handle_index) < 32'(lim);
  assign ver_cur  = rd_vvalid_r ? ram_rd_data : '0;
  assign ver_inc  = ver_cur + VER_W'(1);
  assign ver_new  = (ver_inc == '0) ? VER_W'(1) : ver_inc;
  assign ram_we   = cmd.commit && (item_r.mode == MODE_SPAWN) && found_r;

  always_comb begin
    reserved_nxt           = reserved_r;
    vvalid_nxt             = vvalid_r;
    live_nxt               = live_r;
    hint_nxt               = hint_r;
    out_nxt.ok             = 1'b0;
    out_nxt.result_index   = '0;
    out_nxt.result_version = '0;
    case (item_r.mode)
      MODE_SPAWN: begin
        if (found_r) begin
          reserved_nxt[found_idx_r] = 1'b1;
          vvalid_nxt[found_idx_r]   = 1'b1;
          live_nxt                  = live_r + CNT_W'(1);
          hint_nxt                  = CNT_W'(found_idx_r) + CNT_W'(1);
          out_nxt.ok                = 1'b1;
          out_nxt.result_index      = HIDX_W'(found_idx_r);
          out_nxt.result_version    = ver_new;
        end
      end
      MODE_DESTROY: begin
        if (in_range && reserved_r[hidx]) begin
          reserved_nxt[hidx] = 1'b0;
          live_nxt           = live_r - CNT_W'(1);
          if (32'(hidx) < 32'(hint_r)) begin
            hint_nxt = CNT_W'(hidx);
          end
          out_nxt.ok = 1'b1;
        end
      end
      MODE_CHECK: begin
        out_nxt.ok = (item_r.handle_version != '0) && in_range && reserved_r[hidx]
                     && (ver_cur == item_r.handle_version);
      end
      MODE_CLEAR_ALL: begin
        reserved_nxt = '0;
        live_nxt     = '0;
        hint_nxt     = '0;
        out_nxt.ok   = 1'b1;
      end
      default: begin
        out_nxt.ok = 1'b0;
      end
    endcase
    out_nxt.live_count = LCOUNT_W'(live_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= LIMIT_RESET;
      reserved_r <= '0;
      vvalid_r   <= '0;
      live_r     <= '0;
      hint_r     <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (cmd.commit) begin
        reserved_r <= reserved_nxt;
        vvalid_r   <= vvalid_nxt;
        live_r     <= live_nxt;
        hint_r     <= hint_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r      <= in_data;
      found_r     <= found;
      found_idx_r <= found_idx;
      rd_vvalid_r <= vvalid_r[rd_addr];
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  `GHA_ASSERT_IMPL(a_live_matches_bits, 1'b1,
                   32'(live_r) == 32'($countones(reserved_r)), "live count mismatch")
  `GHA_ASSERT_NEXT(a_failed_spawn_keeps_count,
                   cmd.commit && (item_r.mode == MODE_SPAWN) && !found_r,
                   $stable(live_r), "failed spawn changed count")
  `GHA_ASSERT_IMPL(a_hint_bounded, 1'b1, 32'(hint_r) <= 32'(MAX_SLOTS), "hint beyond table")

endmodule

// ===== hw/rtl/generational_handle_allocator.sv =====
// ---------------------------------------------------------------------------
// generational_handle_allocator
// slot allocator handing out index/version handles with a live count
// ---------------------------------------------------------------------------
// A request is handled in the idle and exec states: in the accept cycle a priority search over
// the reserved bits finds the lowest free slot from the hint up to the slot
// limit and the version ram is read; in the exec state the slot state,
// counters and version are updated and the result register is loaded. The
// exec state waits while the result register still holds an untaken
// result, and the next request is accepted in the cycle after it completes.
// Versions keep per-slot valid bits cleared by reset, so the allocator is
// usable directly after reset. The slot limit is taken only while no request
// is in flight or offered.
module generational_handle_allocator import gha_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gha_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gha_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  gha_cmd_t cmd;

  gha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  gha_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

// ===== dv/gha_handle_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gha_handle_checker
// watches the request, result and slot limit channels of the handle
// allocator, keeps its own copy of the slot table and compares every result
// with the outcome predicted for the oldest open request
// ---------------------------------------------------------------------------
module gha_handle_checker import gha_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  gha_in_t            in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  gha_out_t           out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 open_count,
  output int                 checked_count,
  output int                 full_count,
  output int                 hit_count
);

  logic [MAX_SLOTS_DEF-1:0] slot_busy;
  logic [VER_W-1:0]         slot_ver [MAX_SLOTS_DEF];
  int unsigned              live_slots;
  int unsigned              free_hint;
  logic [LIMIT_W-1:0]       slot_limit;
  gha_out_t                 pending_outcomes [$];

  function automatic gha_out_t allocate_outcome(gha_in_t req);
    int unsigned lim;
    int unsigned i;
    int unsigned idx;
    logic        found;
    logic [VER_W-1:0] nv;
    gha_out_t    res;
    res = '0;
    found = 1'b0;
    idx = 32'(req.handle_index);
    if (slot_limit == 0) lim = 1;
    else if (slot_limit > MAX_SLOTS_DEF) lim = MAX_SLOTS_DEF;
    else lim = 32'(slot_limit);
    case (req.mode)
      MODE_SPAWN: begin
        for (i = free_hint; i < lim && !found; i++) begin
          if (!slot_busy[i]) begin
            found = 1'b1;
            nv = slot_ver[i] + 1'b1;
            if (nv == '0) nv = 1;
            slot_ver[i] = nv;
            slot_busy[i] = 1'b1;
            live_slots++;
            free_hint = i + 1;
            res.ok = 1'b1;
            res.result_index = HIDX_W'(i);
            res.result_version = nv;
          end
        end
        if (!found) full_count++;
      end
      MODE_DESTROY: begin
        if (idx < lim && slot_busy[idx]) begin
          slot_busy[idx] = 1'b0;
          live_slots--;
          if (idx < free_hint) free_hint = idx;
          res.ok = 1'b1;
        end
      end
      MODE_CHECK: begin
        if (req.handle_version != '0 && idx < lim && slot_busy[idx] &&
            slot_ver[idx] == req.handle_version) begin
          res.ok = 1'b1;
          hit_count++;
        end
      end
      MODE_CLEAR_ALL: begin
        slot_busy = '0;
        live_slots = 0;
        free_hint = 0;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.live_count = LCOUNT_W'(live_slots);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [VER_W-1:0] exp_v,
                             input logic [VER_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    gha_out_t want;
    if (!rst_n) begin
      slot_busy = '0;
      for (int k = 0; k < MAX_SLOTS_DEF; k++) slot_ver[k] = '0;
      live_slots = 0;
      free_hint = 0;
      slot_limit = LIMIT_RESET;
      pending_outcomes.delete();
      fail_count = 0;
      checked_count = 0;
      full_count = 0;
      hit_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) slot_limit = cfg_data;
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          $error("result with no request outstanding: %p", out_data);
          fail_count++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("ok", VER_W'(want.ok), VER_W'(out_data.ok));
          check_field("result_index", VER_W'(want.result_index),
                      VER_W'(out_data.result_index));
          check_field("result_version", want.result_version, out_data.result_version);
          check_field("live_count", VER_W'(want.live_count), VER_W'(out_data.live_count));
          checked_count++;
        end
      end
      if (in_valid && !in_stall) pending_outcomes.push_back(allocate_outcome(in_data));
    end
    open_count <= pending_outcomes.size();
  end

endmodule

// ===== dv/generational_handle_allocator_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// generational_handle_allocator_tb
// drives spawn, destroy, check and destroy-all requests under a range of
// slot limits with bursty requests and a stalling receiver; the checker
// beside the allocator predicts and compares every result
// ---------------------------------------------------------------------------
module generational_handle_allocator_tb;
  import gha_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 190;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  gha_in_t            in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  gha_out_t           out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  int fail_count, open_count, checked_count, full_count, hit_count;
  int req_count = 0;
  int cfg_count = 0;
  int quiet_cycles = 0;
  int unsigned cur_lim = MAX_SLOTS_DEF;
  int unsigned burst_left = 1;
  int unsigned stall_kind = 0;
  int unsigned stall_left = 0;
  logic [VER_W-1:0] seen_ver [MAX_SLOTS_DEF] = '{default: '0};
  int unsigned phase_limit [8] = '{64, 3, 127, 1, 17, 0, 40, 9};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  generational_handle_allocator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  gha_handle_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .open_count   (open_count),
    .checked_count(checked_count),
    .full_count   (full_count),
    .hit_count    (hit_count)
  );

  // receiver stall pattern: open stretches, random stalls, solid stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_left = (stall_kind == 2) ? $urandom_range(1, 8) : $urandom_range(4, 60);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= 1'b1;
    endcase
  end

  // remember handed-out versions so checks can carry a slot's current version
  always @(posedge clk) begin
    if (out_valid && !out_stall && out_data.ok && out_data.result_version != '0)
      seen_ver[out_data.result_index] <= out_data.result_version;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(input logic [MODE_W-1:0] mode, input logic [HIDX_W-1:0] idx,
                       input logic [VER_W-1:0] ver);
    gha_in_t req;
    req.mode = mode;
    req.handle_index = idx;
    req.handle_version = ver;
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    req_count++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_count++;
    if (value == 0) cur_lim = 1;
    else if (value > MAX_SLOTS_DEF) cur_lim = MAX_SLOTS_DEF;
    else cur_lim = 32'(value);
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned idx;
    logic [VER_W-1:0] ver;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 4) != 0) idx = $urandom_range(0, $urandom_range(0, cur_lim - 1));
    else idx = $urandom_range(0, MAX_SLOTS_DEF - 1);
    ver = $urandom();
    if (pick < 45) begin
      issue(MODE_SPAWN, HIDX_W'(idx), ver);
    end else if (pick < 75) begin
      issue(MODE_DESTROY, HIDX_W'(idx), ver);
    end else if (pick < 97) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: ver = seen_ver[idx];
        6: ver = seen_ver[idx] - 1'b1;
        7: ver = '0;
        default: ;
      endcase
      issue(MODE_CHECK, HIDX_W'(idx), ver);
    end else begin
      issue(MODE_CLEAR_ALL, HIDX_W'(idx), ver);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // limit of zero behaves as a single slot
    write_limit(LIMIT_W'(0));
    issue(MODE_SPAWN, 0, 0);
    issue(MODE_SPAWN, 0, 0);
    issue(MODE_CHECK, 0, 1);
    issue(MODE_CHECK, 0, 0);
    issue(MODE_CHECK, 63, 32'hFFFF_FFFF);
    issue(MODE_DESTROY, 63, 32'hFFFF_FFFF);
    issue(MODE_DESTROY, 0, 0);
    issue(MODE_DESTROY, 0, 0);
    issue(MODE_SPAWN, 0, 0);

    // limit above range behaves as the full table; hint drops on destroy
    write_limit(LIMIT_W'(127));
    issue(MODE_SPAWN, 0, 0);
    issue(MODE_SPAWN, 0, 0);
    issue(MODE_SPAWN, 0, 0);
    issue(MODE_DESTROY, 1, 0);
    issue(MODE_SPAWN, 0, 0);
    issue(MODE_CHECK, 1, 1);

    // limit lowered below reserved slots, then destroy-all
    write_limit(LIMIT_W'(2));
    issue(MODE_CHECK, 3, 1);
    issue(MODE_DESTROY, 3, 0);
    issue(MODE_SPAWN, 0, 0);
    issue(MODE_CLEAR_ALL, 0, 0);
    issue(MODE_SPAWN, 0, 0);
    issue(MODE_CHECK, 3, 1);

    for (int p = 0; p < 8; p++) begin
      if (p == 7) write_limit(LIMIT_W'($urandom_range(2, 63)));
      else write_limit(LIMIT_W'(phase_limit[p]));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) == 0) wait_idle();
        random_request();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d requests under %0d slot limit settings, %0d results compared",
             req_count, cfg_count, checked_count);
    $display("spawns refused for lack of a free slot: %0d, handle checks found valid: %0d",
             full_count, hit_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== generational_handle_allocator.f =====
+incdir+hw/rtl
hw/rtl/gha_pkg.sv
hw/rtl/gha_ram.sv
hw/rtl/gha_ctrl.sv
hw/rtl/gha_dpath.sv
hw/rtl/generational_handle_allocator.sv
dv/gha_handle_checker.sv
dv/generational_handle_allocator_tb.sv
